// ===== sv/dfc_pkg.sv =====
// Package for the delimited frame capture unit: beat types, command codes,
// frame kinds, delimiter characters and buffer sizing. No dependencies.
package dfc_pkg;

    // Buffer sizing
    localparam int unsigned BUFFER_DEPTH = 1024;
    localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W        = ADDR_W + 1;
    localparam int unsigned LEN_W        = 11;

    // Item commands
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // Frame kinds
    localparam logic [2:0] KIND_IDLE   = 3'd0;
    localparam logic [2:0] KIND_DOLLAR = 3'd1;
    localparam logic [2:0] KIND_HASH   = 3'd2;
    localparam logic [2:0] KIND_BRACE  = 3'd3;
    localparam logic [2:0] KIND_ANGLE  = 3'd4;

    // Delimiter characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
    localparam logic [7:0] CH_LBRACE  = 8'h7B;  // '{'
    localparam logic [7:0] CH_RBRACE  = 8'h7D;  // '}'
    localparam logic [7:0] CH_LANGLE  = 8'h3C;  // '<'
    localparam logic [7:0] CH_RANGLE  = 8'h3E;  // '>'
    localparam logic [7:0] CH_BANG    = 8'h21;  // '!'

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [9:0] read_index;
    } item_t;

    typedef struct packed {
        logic             frame_ready;
        logic [2:0]       frame_kind;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       read_data;
    } result_t;

endpackage

// ===== sv/delimited_frame_capture_unit.sv =====
// Top level of the delimited frame capture unit: frame control, byte buffer
// memory and a two-beat result queue. Depends on dfc_pkg.

// Takes one item beat per cycle while item_stall is low and returns one
// result beat per item, through the read stage and then the result queue.
// Received bytes are written into a single-port synchronous buffer memory
// at accept time; reads return the registered memory output in the next
// cycle, so a read always sees every byte written by earlier items. Results
// pass through a two-beat queue, so the unit keeps accepting while one result
// waits on a stalled output; it stalls its input only when the queue is full
// and the read stage is occupied. The buffer has no reset: reading a slot
// that was never written returns whatever the memory holds.
module delimited_frame_capture_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  dfc_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output dfc_pkg::result_t result
);
    import dfc_pkg::*;

    // Frame control state
    logic [2:0]        kind_reg,   kind_next;
    logic [ADDR_W-1:0] widx_reg,   widx_next;
    logic              ready_reg,  ready_next;
    logic [LEN_W-1:0]  length_reg, length_next;

    // Read stage
    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic              s1_ready_reg;
    logic [2:0]        s1_kind_reg;
    logic [LEN_W-1:0]  s1_length_reg;
    logic [7:0]        rdata_reg;

    // Result queue
    logic [1:0]        qcnt_reg, qcnt_next;
    result_t           q0_reg, q1_reg;

    // Buffer memory
    logic [7:0]        buffer_mem [BUFFER_DEPTH];

    logic              accept;
    logic              q_full;
    logic              push;
    logic              pop;
    logic              wr_en;
    logic              rd_en;
    logic              rd_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [2:0]        kind_a;
    logic [ADDR_W-1:0] idx_a;
    logic [CNT_W-1:0]  idx_inc;
    logic              done;
    result_t           s1_result;

    // Handshake
    assign q_full     = (qcnt_reg == 2'd2);
    assign push       = s1_valid_reg && !q_full;
    assign pop        = result_valid && !result_stall;
    assign item_stall = s1_valid_reg && q_full;
    assign accept     = item_valid && !item_stall;

    // Decode a received byte against the current frame state
    always_comb
    begin
        kind_a = kind_reg;
        idx_a  = widx_reg;
        if (item.rx_byte == CH_LANGLE)
        begin
            kind_a = KIND_ANGLE;
            idx_a  = '0;
        end
        else if (kind_reg == KIND_IDLE)
        begin
            case (item.rx_byte)
                CH_DOLLAR: kind_a = KIND_DOLLAR;
                CH_HASH:   kind_a = KIND_HASH;
                CH_LBRACE: kind_a = KIND_BRACE;
                default:   kind_a = KIND_IDLE;
            endcase
            idx_a = '0;
        end
        idx_inc = CNT_W'(idx_a) + CNT_W'(1);
        done = ((kind_a == KIND_ANGLE) && (item.rx_byte == CH_RANGLE))
            || (((kind_a == KIND_DOLLAR) || (kind_a == KIND_HASH))
                && (item.rx_byte == CH_BANG))
            || ((kind_a == KIND_BRACE) && (item.rx_byte == CH_RBRACE));
    end

    // Next frame state and memory commands
    always_comb
    begin
        kind_next   = kind_reg;
        widx_next   = widx_reg;
        ready_next  = ready_reg;
        length_next = length_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = idx_a;
        rd_addr     = ADDR_W'(item.read_index);
        rd_ok       = (CNT_W'(item.read_index) < CNT_W'(BUFFER_DEPTH));
        if (accept)
        begin
            unique case (item.mode)
                MODE_BYTE:
                begin
                    if (!ready_reg)
                    begin
                        wr_en     = 1'b1;
                        kind_next = kind_a;
                        if (idx_inc == CNT_W'(BUFFER_DEPTH))
                            widx_next = '0;
                        else
                            widx_next = idx_inc[ADDR_W-1:0];
                        if (done)
                        begin
                            ready_next  = 1'b1;
                            length_next = LEN_W'(idx_inc);
                        end
                    end
                end
                MODE_RELEASE:
                begin
                    ready_next = 1'b0;
                    kind_next  = KIND_IDLE;
                end
                MODE_READ:
                begin
                    rd_en = rd_ok;
                end
                default:
                begin
                    rd_en = 1'b0;
                end
            endcase
        end
    end

    // Buffer memory: write on byte beats, registered read on read beats
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buffer_mem[wr_addr] <= item.rx_byte;
        if (rd_en)
            rdata_reg <= buffer_mem[rd_addr];
    end

    // Control state and read stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_IDLE;
            widx_reg     <= '0;
            ready_reg    <= 1'b0;
            length_reg   <= '0;
            s1_valid_reg <= 1'b0;
            qcnt_reg     <= 2'd0;
        end
        else
        begin
            kind_reg   <= kind_next;
            widx_reg   <= widx_next;
            ready_reg  <= ready_next;
            length_reg <= length_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (push)
                s1_valid_reg <= 1'b0;
            qcnt_reg <= qcnt_next;
        end
    end

    // Capture status after the update for the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg   <= rd_en;
            s1_ready_reg  <= ready_next;
            s1_kind_reg   <= kind_next;
            s1_length_reg <= length_next;
        end
    end

    // Assemble the result beat from the read stage
    always_comb
    begin
        s1_result.frame_ready  = s1_ready_reg;
        s1_result.frame_kind   = s1_kind_reg;
        s1_result.frame_length = s1_length_reg;
        s1_result.read_data    = s1_read_reg ? rdata_reg : 8'd0;
    end

    // Result queue count
    always_comb
    begin
        qcnt_next = qcnt_reg;
        if (push && !pop)
            qcnt_next = qcnt_reg + 2'd1;
        else if (pop && !push)
            qcnt_next = qcnt_reg - 2'd1;
    end

    // Result queue: shift on pop, fill the first free slot on push
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (qcnt_reg == 2'd2)
                q0_reg <= q1_reg;
            else if (push)
                q0_reg <= s1_result;
        end
        else if (push && (qcnt_reg == 2'd0))
        begin
            q0_reg <= s1_result;
        end
        if (push && !pop && (qcnt_reg == 2'd1))
            q1_reg <= s1_result;
    end

    assign result_valid = (qcnt_reg != 2'd0);
    assign result       = q0_reg;

endmodule

// ===== bench/delimited_frame_capture_unit_tb.sv =====
// Testbench for delimited_frame_capture_unit: queued stimulus, a clocked driver and monitor,
// and a frame capture predictor checked beat by beat. Depends on dfc_pkg and the unit RTL.
module delimited_frame_capture_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfc_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int unsigned RANDOM_ITEMS  = 1850;
    localparam int unsigned HOLD_CYCLES   = 120;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned PRINT_LIMIT   = 50;

    // Predicted unit state; the buffer is packed so the whole state copies as one value
    typedef struct packed {
        logic [BUFFER_DEPTH-1:0][7:0] mem;
        logic [2:0]                   kind;
        logic [CNT_W-1:0]             widx;
        logic                         ready;
        logic [LEN_W-1:0]             length;
        logic [CNT_W-1:0]             top;     // slots 0..top-1 hold written bytes
    } capture_state_t;

    typedef struct packed {
        logic  drain;    // wait for all results before offering this beat
        item_t beat;
    } pending_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    pending_t       pending_q[$];
    result_t        expected_q[$];
    capture_state_t gen_state = '0;
    capture_state_t chk_state = '0;
    bit             drain_next = 1'b0;
    int unsigned    stim_count = 0;
    int unsigned    fail_count = 0;
    int unsigned    items_accepted = 0;
    int unsigned    results_seen = 0;
    int unsigned    gap_left = 0;
    int unsigned    wait_left = 0;
    int unsigned    hold_left = 0;
    int unsigned    holds_done = 0;

    delimited_frame_capture_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Advance the predicted state by one item and form its status beat
    task automatic capture_step(inout capture_state_t s, input item_t it, output result_t r);
        logic [7:0] b;
        logic [7:0] data;
        logic       done;
        b    = it.rx_byte;
        data = 8'd0;
        done = 1'b0;
        case (it.mode)
            MODE_BYTE:
            begin
                if (!s.ready)
                begin
                    if (b == CH_LANGLE)
                    begin
                        s.kind = KIND_ANGLE;
                        s.widx = '0;
                    end
                    else if (s.kind == KIND_IDLE)
                    begin
                        if (b == CH_DOLLAR)
                            s.kind = KIND_DOLLAR;
                        else if (b == CH_HASH)
                            s.kind = KIND_HASH;
                        else if (b == CH_LBRACE)
                            s.kind = KIND_BRACE;
                        s.widx = '0;
                    end
                    if (s.widx >= BUFFER_DEPTH)
                        s.widx = '0;
                    s.mem[s.widx[ADDR_W-1:0]] = b;
                    s.widx = s.widx + 1'b1;
                    if (s.widx > s.top)
                        s.top = s.widx;
                    if (s.kind == KIND_ANGLE && b == CH_RANGLE)
                        done = 1'b1;
                    else if ((s.kind == KIND_DOLLAR || s.kind == KIND_HASH) && b == CH_BANG)
                        done = 1'b1;
                    else if (s.kind == KIND_BRACE && b == CH_RBRACE)
                        done = 1'b1;
                    if (done)
                    begin
                        s.length = LEN_W'(s.widx);
                        s.ready  = 1'b1;
                    end
                    if (s.widx >= BUFFER_DEPTH)
                        s.widx = '0;
                end
            end
            MODE_RELEASE:
            begin
                s.ready = 1'b0;
                s.kind  = KIND_IDLE;
            end
            MODE_READ:
                data = s.mem[it.read_index];
            default:
                ;
        endcase
        r.frame_ready  = s.ready;
        r.frame_kind   = s.kind;
        r.frame_length = s.length;
        r.read_data    = data;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // Queue one beat; fields the mode does not use get random values
    task automatic queue_item(input logic [1:0] mode, input logic [7:0] rx,
                              input logic [9:0] ridx);
        item_t    it;
        result_t  unused;
        pending_t e;
        it.mode       = mode;
        it.rx_byte    = (mode == MODE_BYTE) ? rx : 8'($urandom);
        it.read_index = (mode == MODE_READ) ? ridx : 10'($urandom);
        if (!(mode == MODE_UNUSED || (mode == MODE_BYTE && gen_state.ready)))
            stim_count++;
        capture_step(gen_state, it, unused);
        e.drain = drain_next;
        e.beat  = it;
        drain_next = 1'b0;
        pending_q.push_back(e);
    endtask

    // Read only slots that already hold a byte
    task automatic queue_read();
        if (gen_state.top != 0)
            queue_item(MODE_READ, 8'd0, 10'($urandom_range(0, int'(gen_state.top) - 1)));
    endtask

    function automatic logic [7:0] body_byte(input logic [7:0] closer);
        logic [7:0] b;
        b = 8'($urandom);
        while (b == closer || b == CH_LANGLE)
            b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] idle_junk();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == CH_DOLLAR || b == CH_HASH || b == CH_LBRACE || b == CH_LANGLE)
            b = 8'($urandom);
        return b;
    endfunction

    // Queue an opener, a body and the matching closer; a restart turns it into an angle frame
    task automatic queue_frame(input logic [2:0] kind, input int unsigned body_len,
                               input bit allow_restart);
        logic [7:0]  opener;
        logic [7:0]  closer;
        int unsigned i;
        case (kind)
            KIND_DOLLAR:
            begin
                opener = CH_DOLLAR;
                closer = CH_BANG;
            end
            KIND_HASH:
            begin
                opener = CH_HASH;
                closer = CH_BANG;
            end
            KIND_BRACE:
            begin
                opener = CH_LBRACE;
                closer = CH_RBRACE;
            end
            default:
            begin
                opener = CH_LANGLE;
                closer = CH_RANGLE;
            end
        endcase
        queue_item(MODE_BYTE, opener, 10'd0);
        for (i = 0; i < body_len; i++)
        begin
            if (allow_restart && $urandom_range(0, 24) == 0)
            begin
                queue_item(MODE_BYTE, CH_LANGLE, 10'd0);
                closer = CH_RANGLE;
            end
            else
                queue_item(MODE_BYTE, body_byte(closer), 10'd0);
        end
        queue_item(MODE_BYTE, closer, 10'd0);
    endtask

    // Driver: hold a stalled beat, otherwise wait out the gap and offer the next one
    always @(posedge clk)
    begin : drive_items
        pending_t e;
        result_t  r;
        bit       quiet;
        if (rst_n)
        begin
            quiet = ((items_accepted / 300) % 4) == 2;
            if (item_valid && !item_stall)
            begin
                capture_step(chk_state, item, r);
                expected_q.push_back(r);
                items_accepted++;
                gap_left = quiet ? 0 : $urandom_range(0, 3);
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left == 0 && pending_q.size() != 0 &&
                    !(pending_q[0].drain && expected_q.size() != 0))
                begin
                    e = pending_q.pop_front();
                    item       <= e.beat;
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: check each accepted result beat and draw the next stall
    always @(posedge clk)
    begin : check_results
        result_t want;
        bit      quiet;
        if (rst_n)
        begin
            quiet = ((results_seen / 300) % 4) == 2;
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result beat with nothing expected", 0, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.frame_ready !== want.frame_ready)
                        report_mismatch("frame_ready", 32'(result.frame_ready),
                                        32'(want.frame_ready));
                    if (result.frame_kind !== want.frame_kind)
                        report_mismatch("frame_kind", 32'(result.frame_kind),
                                        32'(want.frame_kind));
                    if (result.frame_length !== want.frame_length)
                        report_mismatch("frame_length", 32'(result.frame_length),
                                        32'(want.frame_length));
                    if (result.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(result.read_data),
                                        32'(want.read_data));
                end
                results_seen <= results_seen + 1;
                wait_left = quiet ? 0 : $urandom_range(0, 3);
            end
            else if (result_valid && wait_left > 0)
                wait_left--;
            result_stall <= (wait_left != 0) || (hold_left != 0);
        end
    end

    // Hold off the output for a long stretch twice so the unit backs up
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && results_seen >= 400) ||
                 (holds_done == 1 && results_seen >= 1400))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned base;
        int unsigned sel;
        int unsigned long_frames;
        logic [2:0]  kind;

        // Directed: release while idle, unused mode, non-start idle bytes, each frame kind,
        // bytes while ready, a '!' inside a brace frame, a restart, a stray closer
        queue_item(MODE_RELEASE, 8'd0, 10'd0);
        queue_item(MODE_UNUSED, 8'hFF, 10'h3FF);
        queue_item(MODE_BYTE, 8'h00, 10'd0);
        queue_item(MODE_BYTE, 8'hFF, 10'd0);
        queue_item(MODE_READ, 8'd0, 10'd0);
        queue_item(MODE_BYTE, CH_DOLLAR, 10'd0);
        queue_item(MODE_BYTE, 8'h61, 10'd0);
        queue_item(MODE_BYTE, CH_BANG, 10'd0);
        queue_item(MODE_BYTE, 8'h78, 10'd0);
        queue_item(MODE_READ, 8'd0, 10'd2);
        queue_item(MODE_RELEASE, 8'd0, 10'd0);
        queue_item(MODE_BYTE, CH_HASH, 10'd0);
        queue_item(MODE_BYTE, CH_BANG, 10'd0);
        queue_item(MODE_RELEASE, 8'd0, 10'd0);
        queue_item(MODE_BYTE, CH_LBRACE, 10'd0);
        queue_item(MODE_BYTE, CH_BANG, 10'd0);
        queue_item(MODE_BYTE, CH_RBRACE, 10'd0);
        queue_item(MODE_READ, 8'd0, 10'd1);
        queue_item(MODE_RELEASE, 8'd0, 10'd0);
        queue_item(MODE_BYTE, CH_LBRACE, 10'd0);
        queue_item(MODE_BYTE, CH_LANGLE, 10'd0);
        queue_item(MODE_BYTE, 8'h71, 10'd0);
        queue_item(MODE_BYTE, CH_RANGLE, 10'd0);
        queue_item(MODE_RELEASE, 8'd0, 10'd0);
        queue_item(MODE_BYTE, CH_RANGLE, 10'd0);

        // Random: mostly whole frames, with noise, reads and one buffer-length frame
        base        = stim_count;
        long_frames = 0;
        while (stim_count - base < RANDOM_ITEMS)
        begin
            if (long_frames == 0 && stim_count - base >= 600)
            begin
                // Fill every slot so the frame ends on the last one
                drain_next = 1'b1;
                queue_item(MODE_RELEASE, 8'd0, 10'd0);
                queue_frame(KIND_ANGLE, BUFFER_DEPTH - 2, 1'b0);
                queue_read();
                queue_item(MODE_RELEASE, 8'd0, 10'd0);
                long_frames++;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                begin
                    repeat ($urandom_range(0, 2))
                        queue_item(MODE_BYTE, idle_junk(), 10'd0);
                    case ($urandom_range(0, 3))
                        0:       kind = KIND_DOLLAR;
                        1:       kind = KIND_HASH;
                        2:       kind = KIND_BRACE;
                        default: kind = KIND_ANGLE;
                    endcase
                    queue_frame(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                                  : $urandom_range(0, 10),
                                1'b1);
                    repeat ($urandom_range(0, 3))
                    begin
                        case ($urandom_range(0, 2))
                            0:       queue_read();
                            1:       queue_item(MODE_BYTE, 8'($urandom), 10'd0);
                            default: queue_item(MODE_UNUSED, 8'd0, 10'd0);
                        endcase
                    end
                    if ($urandom_range(0, 9) != 0)
                        queue_item(MODE_RELEASE, 8'd0, 10'd0);
                end
                else if (sel < 85)
                    queue_read();
                else if (sel < 95)
                    queue_item(MODE_BYTE, 8'($urandom), 10'd0);
                else
                    queue_item($urandom_range(0, 1) ? MODE_RELEASE : MODE_UNUSED,
                               8'd0, 10'd0);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all beats sent, all results back, then let the pipeline settle
        while (pending_q.size() != 0 || item_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("result beats missing", 0, expected_q.size());

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dfc_pkg.sv
sv/delimited_frame_capture_unit.sv
bench/delimited_frame_capture_unit_tb.sv
